// ----- src/bcsr_pkg.sv -----
// Shared types and codes for the 3x3 block-CSR sparse matrix-vector unit.
package bcsr_pkg;

    localparam int BLOCK_DIM   = 3;
    localparam int BLOCK_COEFS = BLOCK_DIM * BLOCK_DIM;
    localparam int COEF_W      = 32;
    localparam int SUM_W       = 64;
    localparam int ROW_W       = 12;
    localparam int IDX_W       = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ACC  = 1'b1;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [IDX_W-1:0]         t_idx;

    // Control shared by all lanes.
    typedef struct packed {
        logic mul_en;  // capture products of the block in stage 1
        logic acc_en;  // fold products into the accumulator
        logic clear;   // block in stage 2 closes its row
    } t_lane_ctl;

endpackage

// ----- src/bcsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bcsr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/bcsr_lane.sv -----
// One block row lane: three products, then a saturating running sum.
module bcsr_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcsr_pkg::t_lane_ctl i_ctl,
    input  bcsr_pkg::t_coef     i_coef [bcsr_pkg::BLOCK_DIM],
    input  bcsr_pkg::t_coef     i_vec  [bcsr_pkg::BLOCK_DIM],
    output bcsr_pkg::t_sum      o_sum
);
    import bcsr_pkg::*;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    function automatic t_sum sat_add(input t_sum a, input t_sum b);
        t_sum s;
        s = a + b;
        if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
            s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    t_sum r_p [BLOCK_DIM];
    t_sum r_acc;
    t_sum w_x1;
    t_sum w_x2;
    t_sum w_x3;

    // Q16.16 x Q16.16 -> Q32.32, exact in 64 bits
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            for (int k = 0; k < BLOCK_DIM; k++) begin
                r_p[k] <= t_sum'(i_coef[k]) * t_sum'(i_vec[k]);
            end
        end
    end

    // column order 0, 1, 2; each add saturates
    assign w_x1 = sat_add(r_acc, r_p[0]);
    assign w_x2 = sat_add(w_x1, r_p[1]);
    assign w_x3 = sat_add(w_x2, r_p[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.clear ? t_sum'(0) : w_x3;
        end
    end

    assign o_sum = w_x3;

endmodule

// ----- src/bcsr3x3_spmv_unit.sv -----
// Top level of the 3x3 block-CSR sparse matrix-vector multiply unit.
//
// Usage:
//   Input channel (i_valid / o_stall): one beat per item. op = load writes
//   the vector triple a0..a2 at node index; op = accumulate multiplies the
//   nine coefficients by the stored triple at column index and adds each
//   block row into its accumulator. row_end closes the row.
//   Output channel (o_valid / i_stall): one beat per closed row carrying the
//   row number and three saturated Q32.32 sums.
//   A row-closing block's result reaches the outputs by way of the RAM read
//   started at the edge that took it, then the product register, then the
//   accumulate into the output register.
//   Throughput: one item per cycle while o_stall is low, loads and blocks
//   alike, set by the accumulator add chain that closes once a cycle per lane.
//   Loads write at the accepting edge, so a block may follow its vector
//   load in the very next cycle.
//   Reset clears accumulators, row counter and all valid flags; the vector
//   store keeps whatever it held and must be loaded before use.
//   While the receiver stalls, blocks without row_end still flow; a
//   row-closing block waits in stage 2 while an output beat is held, and the
//   stages behind it fill up before o_stall rises.
module bcsr3x3_spmv_unit #(
    parameter int NODES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_op,
    input  bcsr_pkg::t_idx  i_index,
    input  logic            i_row_end,
    input  bcsr_pkg::t_coef i_a0,
    input  bcsr_pkg::t_coef i_a1,
    input  bcsr_pkg::t_coef i_a2,
    input  bcsr_pkg::t_coef i_a3,
    input  bcsr_pkg::t_coef i_a4,
    input  bcsr_pkg::t_coef i_a5,
    input  bcsr_pkg::t_coef i_a6,
    input  bcsr_pkg::t_coef i_a7,
    input  bcsr_pkg::t_coef i_a8,
    output logic            o_valid,
    input  logic            i_stall,
    output bcsr_pkg::t_row  o_row_number,
    output bcsr_pkg::t_sum  o_sum0,
    output bcsr_pkg::t_sum  o_sum1,
    output bcsr_pkg::t_sum  o_sum2
);
    import bcsr_pkg::*;

    localparam int AW    = $clog2(NODES);
    localparam int RAM_W = BLOCK_DIM * COEF_W;

    // input decode
    logic                w_accept;
    logic                w_load;
    logic                w_acc;
    logic                w_in_range;
    logic [AW+IDX_W-1:0] w_idx_wide;
    logic [AW-1:0]       w_addr;
    logic [RAM_W-1:0]    w_q;
    t_coef               w_in_coef [BLOCK_COEFS];

    // stage 1: vector triple read, coefficients held
    logic  r_s1_v;
    logic  r_s1_rend;
    logic  r_s1_inr;
    t_coef r_s1_coef [BLOCK_COEFS];
    t_coef w_vec [BLOCK_DIM];

    // stage 2: products held in lanes
    logic r_s2_v;
    logic r_s2_rend;

    // flow control
    logic w_s2_fire;
    logic w_s2_ready;
    logic w_s1_ready;
    logic w_row_done;

    t_lane_ctl w_ctl;
    t_sum      w_sum [BLOCK_DIM];

    // output register and row count
    logic r_out_v;
    t_row r_out_row;
    t_sum r_out_sum [BLOCK_DIM];
    t_row r_row_cnt;

    assign w_in_coef[0] = i_a0;
    assign w_in_coef[1] = i_a1;
    assign w_in_coef[2] = i_a2;
    assign w_in_coef[3] = i_a3;
    assign w_in_coef[4] = i_a4;
    assign w_in_coef[5] = i_a5;
    assign w_in_coef[6] = i_a6;
    assign w_in_coef[7] = i_a7;
    assign w_in_coef[8] = i_a8;

    assign w_accept   = i_valid && !o_stall;
    assign w_load     = w_accept && (i_op == OP_LOAD);
    assign w_acc      = w_accept && (i_op == OP_ACC);
    assign w_in_range = {20'd0, i_index} < 32'(NODES);
    assign w_idx_wide = (AW+IDX_W)'(i_index);
    assign w_addr     = w_idx_wide[AW-1:0];

    // Stage 2 leaves unless it closes a row and the output beat is stuck.
    assign w_s2_fire  = r_s2_v && (!r_s2_rend || !r_out_v || !i_stall);
    assign w_s2_ready = !r_s2_v || w_s2_fire;
    assign w_s1_ready = !r_s1_v || w_s2_ready;
    assign w_row_done = w_s2_fire && r_s2_rend;
    assign o_stall    = !w_s1_ready;

    // one RAM holds the three components side by side
    bcsr_ram #(
        .WIDTH(RAM_W),
        .DEPTH(NODES)
    ) u_vec_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_load && w_in_range),
        .i_wr_addr(w_addr),
        .i_wr_data({i_a2, i_a1, i_a0}),
        .i_rd_en  (w_acc),
        .i_rd_addr(w_addr),
        .o_rd_data(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_rend <= i_row_end;
            r_s1_inr  <= w_in_range;
            r_s1_coef <= w_in_coef;
        end
    end

    // out-of-store column reads as zeros
    always_comb begin
        for (int k = 0; k < BLOCK_DIM; k++) begin
            w_vec[k] = r_s1_inr ? t_coef'(w_q[k*COEF_W +: COEF_W]) : t_coef'(0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready) begin
            r_s2_rend <= r_s1_rend;
        end
    end

    assign w_ctl.mul_en = r_s1_v && w_s2_ready;
    assign w_ctl.acc_en = w_s2_fire;
    assign w_ctl.clear  = r_s2_rend;

    // one lane per block row
    for (genvar l = 0; l < BLOCK_DIM; l++) begin : g_lane
        t_coef w_lane_coef [BLOCK_DIM];
        for (genvar c = 0; c < BLOCK_DIM; c++) begin : g_col
            assign w_lane_coef[c] = r_s1_coef[l*BLOCK_DIM + c];
        end
        bcsr_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_coef (w_lane_coef),
            .i_vec  (w_vec),
            .o_sum  (w_sum[l])
        );
    end

    // merge: the lanes' row sums and the row number form one beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v   <= 1'b0;
            r_row_cnt <= '0;
        end else if (w_row_done) begin
            r_out_v   <= 1'b1;
            r_row_cnt <= r_row_cnt + 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_done) begin
            r_out_row <= r_row_cnt;
            r_out_sum <= w_sum;
        end
    end

    assign o_valid      = r_out_v;
    assign o_row_number = r_out_row;
    assign o_sum0       = r_out_sum[0];
    assign o_sum1       = r_out_sum[1];
    assign o_sum2       = r_out_sum[2];

    a_row_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_done |=> o_valid && (o_row_number == $past(r_row_cnt)))
        else $error("row beat missing or wrong row number");

    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_done |=> r_row_cnt == $past(r_row_cnt) + 1'b1)
        else $error("row counter did not advance");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !w_row_done) |=> !o_valid)
        else $error("output beat repeated");

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_s2_ready) |=> r_s1_v && $stable(w_q))
        else $error("held stage 1 lost its vector data");

endmodule
